// ----- hw/rtl/pced_pkg.sv -----
package pced_pkg;

    // Timer counter width; delay registers are cut to this width on load
    localparam int TIMER_WIDTH = 24;
    localparam int CFG_WIDTH   = 24;
    localparam int CODE_WIDTH  = 4;
    localparam int COUNT_WIDTH = 4;
    localparam int INDEX_WIDTH = 2;

    typedef logic [TIMER_WIDTH-1:0] t_timer;
    typedef logic [CFG_WIDTH-1:0]   t_cfg;
    typedef logic [CODE_WIDTH-1:0]  t_code;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [INDEX_WIDTH-1:0] t_index;

    // Register indexes
    localparam t_index REG_SEQUENCE_DELAY = 2'd0;
    localparam t_index REG_RESET_DELAY    = 2'd1;

    // Reset values of the delay registers
    localparam t_cfg SEQUENCE_DELAY_RESET = 24'd1000;
    localparam t_cfg RESET_DELAY_RESET    = 24'd5000;

    // Error codes
    localparam t_code ERR_NONE         = 4'd0;
    localparam t_code ERR_OVERCURRENT  = 4'd1;
    localparam t_code ERR_HALL_FAULT   = 4'd2;
    localparam t_code ERR_LOCKED       = 4'd3;
    localparam t_code ERR_SENSOR1      = 4'd4;
    localparam t_code ERR_SENSOR2      = 4'd5;
    localparam t_code ERR_HIGH_BATTERY = 4'd6;
    localparam t_code ERR_OVERHEAT     = 4'd7;
    localparam t_code ERR_UNKNOWN      = 4'd8;

    // Pulse counts with a defined meaning
    localparam t_count CNT_NONE         = 4'd0;
    localparam t_count CNT_OVERCURRENT  = 4'd1;
    localparam t_count CNT_HALL_FAULT   = 4'd3;
    localparam t_count CNT_LOCKED       = 4'd4;
    localparam t_count CNT_SENSOR1      = 4'd5;
    localparam t_count CNT_SENSOR2      = 4'd6;
    localparam t_count CNT_HIGH_BATTERY = 4'd8;
    localparam t_count CNT_OVERHEAT     = 4'd9;
    localparam t_count CNT_MAX          = 4'd15;

    // Map a pulse count to its error code
    function automatic t_code decode_count(input t_count count);
        t_code code;
        case (count)
            CNT_NONE:         code = ERR_NONE;
            CNT_OVERCURRENT:  code = ERR_OVERCURRENT;
            CNT_HALL_FAULT:   code = ERR_HALL_FAULT;
            CNT_LOCKED:       code = ERR_LOCKED;
            CNT_SENSOR1:      code = ERR_SENSOR1;
            CNT_SENSOR2:      code = ERR_SENSOR2;
            CNT_HIGH_BATTERY: code = ERR_HIGH_BATTERY;
            CNT_OVERHEAT:     code = ERR_OVERHEAT;
            default:          code = ERR_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/pced_timer.sv -----
module pced_timer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_load,
    input  pced_pkg::t_timer i_load_value,
    output logic            o_expire
);
    import pced_pkg::*;

    logic   r_armed;
    t_timer r_count;
    logic   n_armed;
    t_timer n_count;

    // Fire on the tick where the count would reach zero
    assign o_expire = r_armed && (r_count <= t_timer'(1));

    // Load on retrigger, else count down while armed
    always_comb begin
        n_armed = r_armed;
        n_count = r_count;
        if (i_step) begin
            if (i_load) begin
                n_armed = 1'b1;
                n_count = i_load_value;
            end else if (r_armed) begin
                if (o_expire) begin
                    n_armed = 1'b0;
                    n_count = '0;
                end else begin
                    n_count = r_count - t_timer'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_count <= '0;
        end else begin
            r_armed <= n_armed;
            r_count <= n_count;
        end
    end

endmodule

// ----- hw/rtl/pulse_count_error_decoder_unit.sv -----
// A sample's error code is registered and shown in the cycle after the sample is accepted.
// Throughput: one sample per cycle unless the output stalls; the register frees as taken.
// The state update (edge detect, two down-counting timers, count decode) is one
// combinational pass from the state registers into the result register.
// Reset (synchronous, active low) clears all state but the output payload,
// sets the error code to none, and loads the delay registers with 1000 and 5000 ticks.
module pulse_count_error_decoder_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_pin_level,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pced_pkg::t_code  o_error_code,
    input  logic             i_cfg_we,
    input  pced_pkg::t_index i_cfg_index,
    input  pced_pkg::t_cfg   i_cfg_data
);
    import pced_pkg::*;

    t_cfg   r_seq_delay;
    t_cfg   r_clr_delay;
    logic   r_last_pin;
    t_count r_pulse_count;
    t_code  r_error;
    logic   r_out_valid;
    t_code  r_out_code;

    t_count n_pulse_count;
    t_code  n_error;
    logic   accept;
    logic   rise;
    logic   seq_expire;
    logic   clr_expire;
    logic   decode;

    // Take a word whenever the output register is empty or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign rise       = i_pin_level && !r_last_pin;
    assign decode     = !rise && seq_expire;

    pced_timer u_seq_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_load       (rise),
        .i_load_value (t_timer'(r_seq_delay)),
        .o_expire     (seq_expire)
    );

    pced_timer u_clr_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_load       (decode),
        .i_load_value (t_timer'(r_clr_delay)),
        .o_expire     (clr_expire)
    );

    // Clear timer first, then the pulse edge or the decode
    always_comb begin
        n_pulse_count = r_pulse_count;
        n_error       = r_error;
        if (clr_expire && (r_pulse_count == CNT_NONE)) begin
            n_error = ERR_NONE;
        end
        if (rise) begin
            if (r_pulse_count != CNT_MAX) begin
                n_pulse_count = r_pulse_count + t_count'(1);
            end
        end else if (seq_expire) begin
            n_error       = decode_count(r_pulse_count);
            n_pulse_count = CNT_NONE;
        end
    end

    // Hold the delay registers; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_delay <= SEQUENCE_DELAY_RESET;
            r_clr_delay <= RESET_DELAY_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_SEQUENCE_DELAY) begin
                r_seq_delay <= i_cfg_data;
            end else if (i_cfg_index == REG_RESET_DELAY) begin
                r_clr_delay <= i_cfg_data;
            end
        end
    end

    // Advance the decoder state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pin    <= 1'b0;
            r_pulse_count <= CNT_NONE;
            r_error       <= ERR_NONE;
        end else if (accept) begin
            r_last_pin    <= i_pin_level;
            r_pulse_count <= n_pulse_count;
            r_error       <= n_error;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_code <= n_error;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_error_code = r_out_code;

endmodule

// ----- verif/tb_pulse_count_error_decoder_unit.sv -----
`default_nettype none

module tb_pulse_count_error_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pced_pkg::*;

    // Indexes with no register behind them; writes to these must be dropped
    localparam t_index REG_SPARE_2 = 2'd2;
    localparam t_index REG_SPARE_3 = 2'd3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_PHASES    = 11;
    localparam int PHASE_WORDS   = 40;
    localparam int SHOWN_ERRORS  = 20;

    // Delay settings of the random phases, extremes included
    localparam int unsigned PHASE_SEQ[NUM_PHASES] =
        '{1, 3, 0, 6, 16777215, 2, 12, 1, 5, 30, 4};
    localparam int unsigned PHASE_CLR[NUM_PHASES] =
        '{1, 8, 16777215, 3, 2, 0, 25, 40, 1, 10, 6};

    // Tracks the decoder state and holds the error codes still to come out
    class error_code_tracker;
        t_cfg   seq_delay;
        t_cfg   clr_delay;
        logic   prev_pin;
        t_count pulses;
        t_timer seq_tmr;
        bit     seq_run;
        t_timer clr_tmr;
        bit     clr_run;
        t_code  err;
        t_code  code_of[16];
        t_code  pending_codes[$];
        int     errors;

        function new();
            foreach (code_of[i]) code_of[i] = ERR_UNKNOWN;
            code_of[CNT_NONE]         = ERR_NONE;
            code_of[CNT_OVERCURRENT]  = ERR_OVERCURRENT;
            code_of[CNT_HALL_FAULT]   = ERR_HALL_FAULT;
            code_of[CNT_LOCKED]       = ERR_LOCKED;
            code_of[CNT_SENSOR1]      = ERR_SENSOR1;
            code_of[CNT_SENSOR2]      = ERR_SENSOR2;
            code_of[CNT_HIGH_BATTERY] = ERR_HIGH_BATTERY;
            code_of[CNT_OVERHEAT]     = ERR_OVERHEAT;
            seq_delay = SEQUENCE_DELAY_RESET;
            clr_delay = RESET_DELAY_RESET;
            prev_pin  = 1'b0;
            pulses    = CNT_NONE;
            seq_tmr   = '0;
            seq_run   = 1'b0;
            clr_tmr   = '0;
            clr_run   = 1'b0;
            err       = ERR_NONE;
            errors    = 0;
        endfunction

        function void write_reg(t_index idx, t_cfg val);
            case (idx)
                REG_SEQUENCE_DELAY: seq_delay = val;
                REG_RESET_DELAY:    clr_delay = val;
                default: ;
            endcase
        endfunction

        // Advance one tick and queue the code the block should show for it
        function void note_pin(logic pin);
            logic rise;
            rise = pin && !prev_pin;
            prev_pin = pin;
            // clear timer goes first
            if (clr_run) begin
                if (clr_tmr <= 1) begin
                    clr_run = 1'b0;
                    clr_tmr = '0;
                    if (pulses == CNT_NONE) err = ERR_NONE;
                end else begin
                    clr_tmr = clr_tmr - 1'b1;
                end
            end
            // then the edge, which beats the sequence timer
            if (rise) begin
                if (pulses != CNT_MAX) pulses = pulses + 1'b1;
                seq_tmr = t_timer'(seq_delay);
                seq_run = 1'b1;
            end else if (seq_run) begin
                if (seq_tmr <= 1) begin
                    seq_run = 1'b0;
                    seq_tmr = '0;
                    err     = code_of[pulses];
                    pulses  = CNT_NONE;
                    clr_tmr = t_timer'(clr_delay);
                    clr_run = 1'b1;
                end else begin
                    seq_tmr = seq_tmr - 1'b1;
                end
            end
            pending_codes.push_back(err);
        endfunction

        function void check_code(t_code got);
            t_code want;
            if (pending_codes.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("%0t ns: error_code expected nothing, actual %0d", $time, got);
                return;
            end
            want = pending_codes.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("%0t ns: error_code mismatch, expected %0d, actual %0d",
                             $time, want, got);
            end
        endfunction

        function int pending();
            return pending_codes.size();
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    logic   i_pin_level;
    logic   o_out_valid;
    logic   i_out_ready;
    t_code  o_error_code;
    logic   i_cfg_we;
    t_index i_cfg_index;
    t_cfg   i_cfg_data;

    error_code_tracker codes;
    bit tx_gaps;
    bit steady;
    int words_sent;

    pulse_count_error_decoder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pin_level  (i_pin_level),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_error_code (o_error_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Watch both handshakes on the edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) codes.note_pin(i_pin_level);
        if (i_rst_n && o_out_valid && i_out_ready) codes.check_code(o_error_code);
    end

    // Stall the result side in bursts, with the stall rate changing now and then
    initial begin
        int unsigned span;
        int unsigned odds;
        span = 0;
        odds = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                span = 150;
                case ($urandom_range(0, 2))
                    0:       odds = 0;
                    1:       odds = 4;
                    default: odds = 12;
                endcase
            end
            span--;
            if (!steady && odds != 0 && $urandom_range(1, odds) == 1) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Hard stop in case the block hangs
    initial begin
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // Send one pin sample word, sometimes after an idle burst
    task automatic send_pin(input logic level);
        if (tx_gaps && !steady && $urandom_range(0, 11) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pin_level <= level;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    // Hold off the sender until every expected code has come out
    task automatic drain_words();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (codes.pending() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_index idx, input t_cfg val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        codes.write_reg(idx, val);
    endtask

    task automatic send_seq(input logic [15:0] bits, input int len);
        int k;
        for (k = len - 1; k >= 0; k--) send_pin(bits[k]);
    endtask

    // A burst of pulses followed by a quiet stretch of some length
    task automatic send_train(input int unsigned sdly, input int unsigned cdly);
        int unsigned edges;
        int unsigned hi;
        int unsigned lo;
        int unsigned room;
        int unsigned quiet;
        edges = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 9);
        repeat (edges) begin
            hi = $urandom_range(1, 2);
            room = (sdly > hi + 1) ? sdly - hi : 1;
            if (room > 6) room = 6;
            // now and then leave a gap long enough to split the sequence
            lo = ($urandom_range(0, 7) == 0) ? sdly + $urandom_range(0, 3)
                                             : $urandom_range(1, room);
            if (lo > 200) lo = $urandom_range(1, room);
            repeat (hi) send_pin(1'b1);
            repeat (lo) send_pin(1'b0);
        end
        case ($urandom_range(0, 2))
            0:       quiet = $urandom_range(0, 4);
            1:       quiet = sdly + $urandom_range(0, 3);
            default: quiet = sdly + cdly + $urandom_range(0, 4);
        endcase
        if (quiet > 200) quiet = $urandom_range(0, 200);
        repeat (quiet) send_pin(1'b0);
    endtask

    initial begin
        int ph;
        int goal;
        codes = new();
        tx_gaps    = 1'b1;
        steady     = 1'b0;
        words_sent = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_pin_level <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_SEQUENCE_DELAY;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: two pin pulses at reset delays, nothing decodes yet
        send_seq(16'b10100, 5);
        drain_words();
        // writes to unused indexes must not touch the delays
        write_reg(REG_SPARE_2, 24'hFFFFFF);
        write_reg(REG_SPARE_3, 24'h000000);
        // zero delays expire at the next accepted sample; the third pulse decodes as hall fault
        write_reg(REG_SEQUENCE_DELAY, 24'd0);
        write_reg(REG_RESET_DELAY, 24'd0);
        send_seq(16'b1000, 4);
        send_seq(16'b100, 3);
        drain_words();
        // two pulses is a count with no meaning, decodes as unknown
        write_reg(REG_SEQUENCE_DELAY, 24'd4);
        write_reg(REG_RESET_DELAY, 24'd2);
        send_seq(16'b10100000, 8);
        drain_words();

        // Reset values written back, one pulse train under them
        write_reg(REG_SEQUENCE_DELAY, SEQUENCE_DELAY_RESET);
        write_reg(REG_RESET_DELAY, RESET_DELAY_RESET);
        send_train(32'(SEQUENCE_DELAY_RESET), 32'(RESET_DELAY_RESET));

        // Random phases, each under its own delay setting
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_words();
            write_reg(REG_SEQUENCE_DELAY, t_cfg'(PHASE_SEQ[ph]));
            write_reg(REG_RESET_DELAY, t_cfg'(PHASE_CLR[ph]));
            tx_gaps = ($urandom_range(0, 2) != 0);
            if (ph >= NUM_PHASES - 2) steady = 1'b1;
            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal) begin
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(4, 20)) send_pin(1'($urandom_range(0, 1)));
                else
                    send_train(PHASE_SEQ[ph], PHASE_CLR[ph]);
            end
        end

        drain_words();
        repeat (4) @(posedge i_clk);
        if (codes.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
